// ===== design/glyph_scale_and_round_top_assert.svh =====
// ----------------------------------------------------------------------------
// Glyph scaler assertion macros
// Shared macros for the concurrent checks in the glyph scaler emitter.
// ----------------------------------------------------------------------------
`ifndef GLYPH_SCALE_AND_ROUND_TOP_ASSERT_SVH
`define GLYPH_SCALE_AND_ROUND_TOP_ASSERT_SVH

// Check that is ignored while reset is asserted.
`define GSR_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that also holds while reset is asserted.
`define GSR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/gsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Glyph scaler package
// Widths, sub-row codes and the row job handed from control to the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsr_pkg;

    localparam int PIX_W           = 6;
    localparam int OUT_W           = 24;
    localparam int IDX_W           = 4;
    localparam int SUB_W           = 2;
    localparam int GLYPH_ROWS_DEF  = 10;

    // Which of the three output rows of a source row is produced.
    typedef enum logic [SUB_W-1:0] {
        SUB_TOP = 2'd0,
        SUB_MID = 2'd1,
        SUB_BOT = 2'd2
    } sub_t;

    // One emission job: the held row with its neighbors and, when the new
    // row closes the glyph, that row as a second source row.
    typedef struct packed {
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] cur;
        logic [PIX_W-1:0] below;
        logic [IDX_W-1:0] idx;
        logic             two_rows;
    } job_t;

endpackage

// ===== design/gsr_if.sv =====
// ----------------------------------------------------------------------------
// Glyph scaler channel interfaces
// Valid/ready channels for glyph rows, scaled rows and the mode register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gsr_row_if;
    logic                      valid;
    logic                      ready;
    logic [gsr_pkg::PIX_W-1:0] row_pixels;
    logic                      glyph_start;

    modport source (output valid, output row_pixels, output glyph_start, input ready);
    modport sink   (input valid, input row_pixels, input glyph_start, output ready);
endinterface

interface gsr_res_if;
    logic                      valid;
    logic                      ready;
    logic [gsr_pkg::OUT_W-1:0] out_pixels;
    logic [gsr_pkg::SUB_W-1:0] sub_row;
    logic [gsr_pkg::IDX_W-1:0] source_row;
    logic                      run_last;
    logic                      glyph_last;

    modport source (output valid, output out_pixels, output sub_row, output source_row,
                    output run_last, output glyph_last, input ready);
    modport sink   (input valid, input out_pixels, input sub_row, input source_row,
                    input run_last, input glyph_last, output ready);
endinterface

interface gsr_cfg_if;
    logic valid;
    logic ready;
    logic graphics_mode;

    modport source (output valid, output graphics_mode, input ready);
    modport sink   (input valid, input graphics_mode, output ready);
endinterface

// ===== design/gsr_row_ctrl.sv =====
// ----------------------------------------------------------------------------
// Glyph scaler row control
// Holds one row of delay and the row above it, counts rows within the glyph
// and forms the emission job for each incoming row.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsr_row_ctrl #(
    parameter int GLYPH_ROWS = gsr_pkg::GLYPH_ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    gsr_row_if.sink             glyph_row,
    input  logic                job_ready,
    output gsr_pkg::job_t       job,
    output logic                job_load
);

    localparam logic [gsr_pkg::IDX_W-1:0] LAST_IDX = gsr_pkg::IDX_W'(GLYPH_ROWS - 1);

    logic [gsr_pkg::PIX_W-1:0] held_row_reg;
    logic [gsr_pkg::PIX_W-1:0] above_reg;
    logic [gsr_pkg::IDX_W-1:0] count_reg;
    logic                      held_valid_reg;

    logic                      accept;
    logic                      new_glyph;
    logic [gsr_pkg::IDX_W-1:0] next_idx;
    logic                      closes_glyph;

    // A row is taken whenever the emitter can queue its job.
    assign glyph_row.ready = job_ready;
    assign accept          = glyph_row.valid && glyph_row.ready;

    // A marked start, or nothing held, begins a new glyph without output.
    assign new_glyph    = glyph_row.glyph_start || !held_valid_reg;
    assign next_idx     = count_reg + gsr_pkg::IDX_W'(1);
    assign closes_glyph = (next_idx == LAST_IDX);

    // Job for the held row; the glyph's last row rides along as a second row.
    always_comb
    begin
        job.above    = above_reg;
        job.cur      = held_row_reg;
        job.below    = glyph_row.row_pixels;
        job.idx      = count_reg;
        job.two_rows = closes_glyph;
        job_load     = accept && !new_glyph;
    end

    // Row delay line and row counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_row_reg   <= '0;
            above_reg      <= '0;
            count_reg      <= '0;
            held_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (new_glyph)
            begin
                held_row_reg   <= glyph_row.row_pixels;
                above_reg      <= '0;
                count_reg      <= '0;
                held_valid_reg <= 1'b1;
            end
            else if (closes_glyph)
            begin
                held_row_reg   <= '0;
                above_reg      <= '0;
                count_reg      <= '0;
                held_valid_reg <= 1'b0;
            end
            else
            begin
                above_reg    <= held_row_reg;
                held_row_reg <= glyph_row.row_pixels;
                count_reg    <= next_idx;
            end
        end
    end

endmodule

// ===== design/gsr_emitter.sv =====
// ----------------------------------------------------------------------------
// Glyph scaler row emitter
// Steps through the three output rows of each queued source row and, unless
// stalled, scales and rounds one row per cycle into the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "glyph_scale_and_round_top_assert.svh"

module gsr_emitter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           graphics_mode,
    input  gsr_pkg::job_t  job,
    input  logic           job_load,
    output logic           job_ready,
    gsr_res_if.source      scaled_row
);

    // Scale one source row to 24 columns, rounding inner corners of blanks.
    function automatic logic [gsr_pkg::OUT_W-1:0] scale_row(
        input logic [gsr_pkg::PIX_W-1:0] above,
        input logic [gsr_pkg::PIX_W-1:0] cur,
        input logic [gsr_pkg::PIX_W-1:0] below,
        input gsr_pkg::sub_t             sub,
        input logic                      gm
    );
        logic [gsr_pkg::OUT_W-1:0]   acc;
        logic [gsr_pkg::PIX_W+1:0]   ext;
        logic [gsr_pkg::PIX_W-1:0]   nb;
        logic                        round;
        acc = '0;
        ext = {1'b0, cur, 1'b0};
        nb  = (sub == gsr_pkg::SUB_TOP) ? above : below;
        for (int p = 0; p < gsr_pkg::PIX_W; p++)
        begin
            if (cur[p])
            begin
                acc[4*p +: 4] = 4'hF;
            end
            else
            begin
                round          = !gm && (sub != gsr_pkg::SUB_MID) && nb[p];
                acc[4*p + 3]   = round && ext[p + 2];
                acc[4*p]       = round && ext[p];
            end
        end
        return acc;
    endfunction

    gsr_pkg::job_t             job_reg;
    logic                      busy_reg;
    gsr_pkg::sub_t             sub_reg;
    logic                      phase_reg;

    logic                      out_valid_reg;
    logic [gsr_pkg::OUT_W-1:0] out_pixels_reg;
    gsr_pkg::sub_t             out_sub_reg;
    logic [gsr_pkg::IDX_W-1:0] out_idx_reg;
    logic                      run_last_reg;
    logic                      glyph_last_reg;

    logic                      out_load;
    logic                      final_step;
    logic [gsr_pkg::PIX_W-1:0] sel_above;
    logic [gsr_pkg::PIX_W-1:0] sel_cur;
    logic [gsr_pkg::PIX_W-1:0] sel_below;
    logic [gsr_pkg::IDX_W-1:0] sel_idx;
    gsr_pkg::sub_t             sub_next;
    logic                      phase_next;

    // The result register refills when it is empty or being drained.
    assign out_load   = busy_reg && (!out_valid_reg || scaled_row.ready);
    assign final_step = (sub_reg == gsr_pkg::SUB_BOT) && (phase_reg || !job_reg.two_rows);
    assign job_ready  = !busy_reg || (out_load && final_step);

    // Second phase moves the window down one row, with blank below the glyph.
    always_comb
    begin
        if (phase_reg)
        begin
            sel_above = job_reg.cur;
            sel_cur   = job_reg.below;
            sel_below = '0;
            sel_idx   = job_reg.idx + gsr_pkg::IDX_W'(1);
        end
        else
        begin
            sel_above = job_reg.above;
            sel_cur   = job_reg.cur;
            sel_below = job_reg.below;
            sel_idx   = job_reg.idx;
        end
    end

    // Sub-row sequencing within the job.
    always_comb
    begin
        phase_next = phase_reg;
        unique case (sub_reg)
            gsr_pkg::SUB_TOP: sub_next = gsr_pkg::SUB_MID;
            gsr_pkg::SUB_MID: sub_next = gsr_pkg::SUB_BOT;
            gsr_pkg::SUB_BOT:
            begin
                sub_next   = gsr_pkg::SUB_TOP;
                phase_next = 1'b1;
            end
            default:          sub_next = gsr_pkg::SUB_TOP;
        endcase
    end

    // Job control and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            sub_reg       <= gsr_pkg::SUB_TOP;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (job_load)
            begin
                busy_reg  <= 1'b1;
                sub_reg   <= gsr_pkg::SUB_TOP;
                phase_reg <= 1'b0;
            end
            else if (out_load)
            begin
                if (final_step)
                begin
                    busy_reg <= 1'b0;
                end
                sub_reg   <= sub_next;
                phase_reg <= phase_next;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (scaled_row.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Job payload and result payload.
    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            job_reg <= job;
        end
        if (out_load)
        begin
            out_pixels_reg <= scale_row(sel_above, sel_cur, sel_below, sub_reg, graphics_mode);
            out_sub_reg    <= sub_reg;
            out_idx_reg    <= sel_idx;
            run_last_reg   <= final_step;
            glyph_last_reg <= phase_reg && (sub_reg == gsr_pkg::SUB_BOT);
        end
    end

    assign scaled_row.valid      = out_valid_reg;
    assign scaled_row.out_pixels = out_pixels_reg;
    assign scaled_row.sub_row    = out_sub_reg;
    assign scaled_row.source_row = out_idx_reg;
    assign scaled_row.run_last   = run_last_reg;
    assign scaled_row.glyph_last = glyph_last_reg;

    `GSR_ASSERT_RUN(a_job_slot_free, job_load |-> job_ready, "job loaded while emitter busy")
    `GSR_ASSERT_RUN(a_glyph_last_bottom, out_valid_reg && glyph_last_reg |-> run_last_reg && out_sub_reg == gsr_pkg::SUB_BOT, "glyph end not on final bottom row")
    `GSR_ASSERT_RUN(a_job_done, out_load && final_step && !job_load |=> !busy_reg, "emitter still busy after final row")
    `GSR_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !busy_reg && !out_valid_reg, "emitter active in reset")

endmodule

// ===== design/glyph_scale_and_round_top.sv =====
// ----------------------------------------------------------------------------
// Glyph scale and round
// Scales 6-pixel glyph rows into 24-pixel rows, three output rows each, with
// optional corner rounding.
// ----------------------------------------------------------------------------
// Each glyph row is held for one row time so that the row below is known;
// the held row is then emitted as three 24-bit rows, one per cycle while
// the output is not stalled, from a result register that the output
// handshake drains. The next row is taken in the same cycle as the previous
// row's last output row is loaded, so the one-row-per-cycle emitter paces
// the input. A glyph's first row produces nothing; its last row also flushes
// itself, 6 output rows in all. graphics_mode is to be written only while
// the block is idle (the block does not enforce this) and turns rounding off.
`timescale 1ns / 1ps

module glyph_scale_and_round_top #(
    parameter int GLYPH_ROWS = gsr_pkg::GLYPH_ROWS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    gsr_cfg_if.sink    cfg,
    gsr_row_if.sink    glyph_row,
    gsr_res_if.source  scaled_row
);

    gsr_pkg::job_t job;
    logic          job_load;
    logic          job_ready;
    logic          graphics_mode_reg;

    // Mode register; every configuration transfer is taken at once.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            graphics_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            graphics_mode_reg <= cfg.graphics_mode;
        end
    end

    // Row delay and job formation.
    gsr_row_ctrl #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_row_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .glyph_row (glyph_row),
        .job_ready (job_ready),
        .job       (job),
        .job_load  (job_load)
    );

    // Scaling, rounding and result register.
    gsr_emitter u_emitter (
        .clk           (clk),
        .rst_n         (rst_n),
        .graphics_mode (graphics_mode_reg),
        .job           (job),
        .job_load      (job_load),
        .job_ready     (job_ready),
        .scaled_row    (scaled_row)
    );

endmodule
